>>> hw/rtl/dirty_tile_rect_marker_macros.svh
// Assertion macros for the dirty-tile rectangle marker checker.
// Expects signals named aclk and aresetn in the scope of each use.
`ifndef DIRTY_TILE_RECT_MARKER_MACROS_SVH
`define DIRTY_TILE_RECT_MARKER_MACROS_SVH

// Check a property outside reset.
`define DTRM_ASSERT_RUN(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("dirty_tile_rect_marker: run-time check failed");

// Check a property at every edge, reset included.
`define DTRM_ASSERT_ANY(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("dirty_tile_rect_marker: reset check failed");

`endif

>>> hw/rtl/dtrm_pkg.sv
// Shared types and constants for the dirty-tile rectangle marker.
// No dependencies; used by dtrm_rect_decode and dirty_tile_rect_marker.
`default_nettype none

package dtrm_pkg;

    localparam int DEF_MAP_COLUMNS = 22;
    localparam int DEF_MAP_ROWS    = 16;
    localparam int DEF_TILE_SHIFT  = 4;

    // Upper bounds of the map geometry; control vectors are sized to these.
    localparam int MAX_MAP_COLUMNS = 64;
    localparam int MAX_MAP_ROWS    = 64;

    localparam int PX_W  = 16;
    localparam int SEL_W = 6;

    typedef enum logic [1:0] {
        CMD_MARK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // Decoded rectangle: acceptance plus the column and row masks to set.
    typedef struct packed {
        logic                       accept;
        logic [MAX_MAP_COLUMNS-1:0] col_mask;
        logic [MAX_MAP_ROWS-1:0]    row_en;
    } rect_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/dtrm_rect_decode.sv
// Pixel rectangle to tile masks: shift, reject, clamp and decode.
// Depends on dtrm_pkg.
`default_nettype none

module dtrm_rect_decode #(
    parameter int MAP_COLUMNS = dtrm_pkg::DEF_MAP_COLUMNS,
    parameter int MAP_ROWS    = dtrm_pkg::DEF_MAP_ROWS,
    parameter int TILE_SHIFT  = dtrm_pkg::DEF_TILE_SHIFT
) (
    input  wire logic signed [dtrm_pkg::PX_W-1:0] left_px,
    input  wire logic signed [dtrm_pkg::PX_W-1:0] top_px,
    input  wire logic signed [dtrm_pkg::PX_W-1:0] right_px,
    input  wire logic signed [dtrm_pkg::PX_W-1:0] bottom_px,
    output dtrm_pkg::rect_ctl_t                   ctl
);

    localparam int TW = dtrm_pkg::PX_W + 1;
    localparam logic signed [TW-1:0] COL_LAST = TW'(MAP_COLUMNS - 1);
    localparam logic signed [TW-1:0] ROW_CNT  = TW'(MAP_ROWS);

    logic signed [TW-1:0] xt1, yt1, xt2, yt2;
    logic signed [TW-1:0] x_lo, x_hi, y_lo, y_hi;
    logic                 reject;

    // Arithmetic shift rounds toward minus infinity.
    assign xt1 = TW'(left_px   >>> TILE_SHIFT);
    assign yt1 = TW'(top_px    >>> TILE_SHIFT);
    assign xt2 = TW'(right_px  >>> TILE_SHIFT);
    assign yt2 = TW'(bottom_px >>> TILE_SHIFT);

    // A top tile equal to the row count passes here but selects no row.
    assign reject = (xt1 >= COL_LAST) || (yt1 > ROW_CNT) ||
                    (xt2 < 0) || (yt2 < 0);

    assign x_lo = (xt1 < 0) ? '0 : xt1;
    assign y_lo = (yt1 < 0) ? '0 : yt1;
    assign x_hi = (xt2 >= COL_LAST) ? COL_LAST - TW'(1) : xt2;
    assign y_hi = (yt2 >= ROW_CNT)  ? ROW_CNT  - TW'(1) : yt2;

    always_comb begin
        ctl        = '0;
        ctl.accept = !reject;
        for (int c = 0; c < dtrm_pkg::MAX_MAP_COLUMNS; c++) begin
            ctl.col_mask[c] = !reject && (c < MAP_COLUMNS) &&
                              (TW'(c) >= x_lo) && (TW'(c) <= x_hi);
        end
        for (int r = 0; r < dtrm_pkg::MAX_MAP_ROWS; r++) begin
            ctl.row_en[r] = !reject && (r < MAP_ROWS) &&
                            (TW'(r) >= y_lo) && (TW'(r) <= y_hi);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dirty_tile_rect_marker.sv
// Dirty-tile rectangle marker: top level with the map registers and handshake.
// Depends on dtrm_pkg and dtrm_rect_decode.
//
// Usage:
//   Requests arrive on the s_ channel (valid/ready). s_cmd selects the request:
//   mark a pixel rectangle, read one map row, or clear the whole map.
//   Every request produces exactly one response on the m_ channel: m_accepted
//   reports whether a mark was accepted, m_row_bits returns a row for a
//   read (bit i is tile column i) and is zero otherwise.
//   The map is a bank of MAP_ROWS flip-flop rows; a mark ORs its column mask
//   into all selected rows in the same cycle.
//   Pipeline: the input register loads at the accepting edge and the result
//   register when the request advances into a free result slot; m_valid rises
//   as the result register loads, and the response is taken while m_ready is high.
//   Throughput: one request per cycle while m_ready stays high; both the
//   rectangle decode and the row update are combinational logic.
//   Requests take effect in arrival order, so a read sees every earlier mark
//   and clear.
//   Reset (aresetn low, synchronous) empties both stages and clears the map.
//   When the receiver stalls, the response holds in the result register and
//   the input register still takes one more request; further requests wait
//   with s_ready low until m_ready returns.
`default_nettype none

module dirty_tile_rect_marker #(
    parameter int MAP_COLUMNS = dtrm_pkg::DEF_MAP_COLUMNS,
    parameter int MAP_ROWS    = dtrm_pkg::DEF_MAP_ROWS,
    parameter int TILE_SHIFT  = dtrm_pkg::DEF_TILE_SHIFT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [1:0]                          s_cmd,
    input  wire logic signed [dtrm_pkg::PX_W-1:0]    s_left_px,
    input  wire logic signed [dtrm_pkg::PX_W-1:0]    s_top_px,
    input  wire logic signed [dtrm_pkg::PX_W-1:0]    s_right_px,
    input  wire logic signed [dtrm_pkg::PX_W-1:0]    s_bottom_px,
    input  wire logic [dtrm_pkg::SEL_W-1:0]          s_row_select,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_accepted,
    output logic [MAP_COLUMNS-1:0]                   m_row_bits
);

    localparam int ROW_IDX_W = $clog2(MAP_ROWS);

    // Input register stage.
    logic                                 in_valid_reg, in_valid_next;
    logic [1:0]                           in_cmd_reg;
    logic signed [dtrm_pkg::PX_W-1:0]     in_left_reg, in_top_reg;
    logic signed [dtrm_pkg::PX_W-1:0]     in_right_reg, in_bottom_reg;
    logic [dtrm_pkg::SEL_W-1:0]           in_sel_reg;

    // Result register stage.
    logic                                 out_valid_reg, out_valid_next;
    logic                                 out_accepted_reg, out_accepted_next;
    logic [MAP_COLUMNS-1:0]               out_bits_reg, out_bits_next;

    // Dirty map.
    logic [MAP_COLUMNS-1:0]               map_reg  [MAP_ROWS];
    logic [MAP_COLUMNS-1:0]               map_next [MAP_ROWS];

    logic                                 s_fire, advance, out_free;
    logic                                 sel_in_range;
    dtrm_pkg::cmd_t                       cmd;
    dtrm_pkg::rect_ctl_t                  rect_ctl;

    dtrm_rect_decode #(
        .MAP_COLUMNS (MAP_COLUMNS),
        .MAP_ROWS    (MAP_ROWS),
        .TILE_SHIFT  (TILE_SHIFT)
    ) u_decode (
        .left_px   (in_left_reg),
        .top_px    (in_top_reg),
        .right_px  (in_right_reg),
        .bottom_px (in_bottom_reg),
        .ctl       (rect_ctl)
    );

    // Advance the held request when the result slot is empty or draining.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;
    assign s_fire   = s_valid && s_ready;

    assign cmd          = dtrm_pkg::cmd_t'(in_cmd_reg);
    assign sel_in_range = {1'b0, in_sel_reg} < (dtrm_pkg::SEL_W + 1)'(MAP_ROWS);

    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_comb begin
        out_accepted_next = 1'b0;
        out_bits_next     = '0;
        for (int r = 0; r < MAP_ROWS; r++) begin
            map_next[r] = map_reg[r];
        end
        case (cmd)
            dtrm_pkg::CMD_MARK: begin
                out_accepted_next = rect_ctl.accept;
                for (int r = 0; r < MAP_ROWS; r++) begin
                    if (rect_ctl.row_en[r]) begin
                        map_next[r] = map_reg[r] | rect_ctl.col_mask[MAP_COLUMNS-1:0];
                    end
                end
            end
            dtrm_pkg::CMD_READ: begin
                if (sel_in_range) begin
                    out_bits_next = map_reg[in_sel_reg[ROW_IDX_W-1:0]];
                end
            end
            dtrm_pkg::CMD_CLEAR: begin
                for (int r = 0; r < MAP_ROWS; r++) begin
                    map_next[r] = '0;
                end
            end
            default: begin
                // Unused code: respond with zeros, touch nothing.
            end
        endcase
    end

    // Control state and the map.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < MAP_ROWS; r++) begin
                map_reg[r] <= '0;
            end
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                for (int r = 0; r < MAP_ROWS; r++) begin
                    map_reg[r] <= map_next[r];
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg    <= s_cmd;
            in_left_reg   <= s_left_px;
            in_top_reg    <= s_top_px;
            in_right_reg  <= s_right_px;
            in_bottom_reg <= s_bottom_px;
            in_sel_reg    <= s_row_select;
        end
        if (advance) begin
            out_accepted_reg <= out_accepted_next;
            out_bits_reg     <= out_bits_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_accepted = out_accepted_reg;
    assign m_row_bits = out_bits_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dtrm_checker.sv
// Port-level checks for dirty_tile_rect_marker, bound to the top level.
// Depends on dtrm_pkg and dirty_tile_rect_marker_macros.svh.
`default_nettype none

`include "dirty_tile_rect_marker_macros.svh"

module dtrm_checker #(
    parameter int MAP_COLUMNS = dtrm_pkg::DEF_MAP_COLUMNS
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_valid,
    input wire logic                   s_ready,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic                   m_accepted,
    input wire logic [MAP_COLUMNS-1:0] m_row_bits
);

    // Reset drops any pending response.
    `DTRM_ASSERT_ANY(a_reset_empties, !aresetn |=> !m_valid)

    // A stalled response holds.
    `DTRM_ASSERT_RUN(a_stall_holds,
        m_valid && !m_ready |=> m_valid && $stable(m_accepted) && $stable(m_row_bits))

    // Only a mark reports acceptance, and only a read returns row bits.
    `DTRM_ASSERT_RUN(a_fields_exclusive, m_valid |-> !(m_accepted && (m_row_bits != '0)))

    // A fresh response comes from a request that passed straight through the input and result registers.
    `DTRM_ASSERT_RUN(a_two_cycle_latency, $rose(m_valid) |-> $past(s_valid && s_ready, 2))

endmodule

bind dirty_tile_rect_marker dtrm_checker #(
    .MAP_COLUMNS (MAP_COLUMNS)
) u_dtrm_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_accepted (m_accepted),
    .m_row_bits (m_row_bits)
);

`default_nettype wire

>>> tb/sv/dirty_tile_rect_marker_checker.sv
// Response checker for the dirty-tile rectangle marker: keeps its own tile map,
// predicts the response of every accepted request and checks the m_ channel in order.
// Depends on dtrm_pkg for the pixel and row-select widths, the command codes and the default geometry.
`timescale 1ns / 100ps

module dirty_tile_rect_marker_checker #(
    parameter int MAP_COLUMNS = dtrm_pkg::DEF_MAP_COLUMNS,
    parameter int MAP_ROWS    = dtrm_pkg::DEF_MAP_ROWS,
    parameter int TILE_SHIFT  = dtrm_pkg::DEF_TILE_SHIFT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [1:0]                           s_cmd,
    input  logic signed [dtrm_pkg::PX_W-1:0]     s_left_px,
    input  logic signed [dtrm_pkg::PX_W-1:0]     s_top_px,
    input  logic signed [dtrm_pkg::PX_W-1:0]     s_right_px,
    input  logic signed [dtrm_pkg::PX_W-1:0]     s_bottom_px,
    input  logic [dtrm_pkg::SEL_W-1:0]           s_row_select,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic                                 m_accepted,
    input  logic [MAP_COLUMNS-1:0]               m_row_bits,
    output int                                   error_count,
    output int                                   responses_owed
);
    import dtrm_pkg::*;

    typedef struct packed {
        logic                   accepted;
        logic [MAP_COLUMNS-1:0] row_bits;
    } map_response_t;

    logic [MAP_COLUMNS-1:0] tile_map [MAP_ROWS];
    map_response_t          owed_responses [$];

    initial begin
        error_count    = 0;
        responses_owed = 0;
    end

    // Arithmetic shift: negative pixels round toward minus infinity.
    function automatic int px_to_tile(input logic signed [PX_W-1:0] px);
        int wide;
        wide = px;
        return wide >>> TILE_SHIFT;
    endfunction

    // Apply the request on the s_ channel to the tile map and form its response.
    task automatic predict_map_response(output map_response_t rsp);
        int xt1, yt1, xt2, yt2;
        rsp = '0;
        case (s_cmd)
            CMD_MARK: begin
                xt1 = px_to_tile(s_left_px);
                yt1 = px_to_tile(s_top_px);
                xt2 = px_to_tile(s_right_px);
                yt2 = px_to_tile(s_bottom_px);
                // A top tile equal to the row count still counts as accepted.
                if (xt1 < MAP_COLUMNS - 1 && yt1 <= MAP_ROWS && xt2 >= 0 && yt2 >= 0) begin
                    rsp.accepted = 1'b1;
                    if (xt1 < 0) xt1 = 0;
                    if (yt1 < 0) yt1 = 0;
                    // The last column is never marked.
                    if (xt2 > MAP_COLUMNS - 2) xt2 = MAP_COLUMNS - 2;
                    if (yt2 > MAP_ROWS - 1) yt2 = MAP_ROWS - 1;
                    for (int y = yt1; y <= yt2; y++) begin
                        for (int x = xt1; x <= xt2; x++) begin
                            tile_map[y][x] = 1'b1;
                        end
                    end
                end
            end
            CMD_READ: begin
                if (s_row_select < MAP_ROWS) rsp.row_bits = tile_map[s_row_select];
            end
            CMD_CLEAR: begin
                foreach (tile_map[r]) tile_map[r] = '0;
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        map_response_t want;
        map_response_t got;
        if (!aresetn) begin
            foreach (tile_map[r]) tile_map[r] = '0;
            owed_responses.delete();
        end else begin
            // Check responses before logging this edge's request: it cannot answer yet.
            if (m_valid && m_ready) begin
                got = {m_accepted, m_row_bits};
                if (owed_responses.size() == 0) begin
                    $error("unexpected response: accepted %0d, row_bits 0x%0h",
                           got.accepted, got.row_bits);
                    error_count++;
                end else begin
                    want = owed_responses.pop_front();
                    if (got.accepted !== want.accepted) begin
                        $error("accepted: expected %0d, actual %0d",
                               want.accepted, got.accepted);
                        error_count++;
                    end
                    if (got.row_bits !== want.row_bits) begin
                        $error("row_bits: expected 0x%0h, actual 0x%0h",
                               want.row_bits, got.row_bits);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_map_response(want);
                owed_responses.push_back(want);
            end
        end
        responses_owed = owed_responses.size();
    end

endmodule

>>> tb/sv/dirty_tile_rect_marker_tb.sv
// Testbench top for the dirty-tile rectangle marker: clock, reset and request stimulus,
// response back-pressure and the final verdict.
// Depends on dtrm_pkg, dirty_tile_rect_marker and dirty_tile_rect_marker_checker.
`timescale 1ns / 100ps

module dirty_tile_rect_marker_tb;
    import dtrm_pkg::*;

    localparam int MAP_COLUMNS      = DEF_MAP_COLUMNS;
    localparam int MAP_ROWS         = DEF_MAP_ROWS;
    localparam int TILE_SHIFT       = DEF_TILE_SHIFT;
    localparam int TILE_PX          = 1 << TILE_SHIFT;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int RANDOM_PER_PHASE = 350;
    localparam int LONG_HOLD_CYCLES = 64;
    // The command field has one code the block leaves unused.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_cmd        = CMD_MARK;
    logic signed [PX_W-1:0] s_left_px    = '0;
    logic signed [PX_W-1:0] s_top_px     = '0;
    logic signed [PX_W-1:0] s_right_px   = '0;
    logic signed [PX_W-1:0] s_bottom_px  = '0;
    logic [SEL_W-1:0]       s_row_select = '0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic                   m_accepted;
    logic [MAP_COLUMNS-1:0] m_row_bits;

    int error_count;
    int responses_owed;
    int cycle_count      = 0;
    int src_idle_pct     = 0;
    int sink_idle_pct    = 0;
    int sink_hold_cycles = 0;

    dirty_tile_rect_marker #(
        .MAP_COLUMNS (MAP_COLUMNS),
        .MAP_ROWS    (MAP_ROWS),
        .TILE_SHIFT  (TILE_SHIFT)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_left_px    (s_left_px),
        .s_top_px     (s_top_px),
        .s_right_px   (s_right_px),
        .s_bottom_px  (s_bottom_px),
        .s_row_select (s_row_select),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_accepted   (m_accepted),
        .m_row_bits   (m_row_bits)
    );

    dirty_tile_rect_marker_checker #(
        .MAP_COLUMNS (MAP_COLUMNS),
        .MAP_ROWS    (MAP_ROWS),
        .TILE_SHIFT  (TILE_SHIFT)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_left_px      (s_left_px),
        .s_top_px       (s_top_px),
        .s_right_px     (s_right_px),
        .s_bottom_px    (s_bottom_px),
        .s_row_select   (s_row_select),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_accepted     (m_accepted),
        .m_row_bits     (m_row_bits),
        .error_count    (error_count),
        .responses_owed (responses_owed)
    );

    // 2 ns clock, 1 ns high and 1 ns low.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog: end the run if the handshakes ever lock up.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("dirty_tile_rect_marker_tb: done, errors");
            $finish;
        end
    end

    // Receiver: drop m_ready at random, or hold it low for a whole stretch
    // when the stimulus asks for one. The stretch is counted down here.
    initial begin
        forever begin
            @(negedge aclk);
            if (sink_hold_cycles > 0) begin
                m_ready <= 1'b0;
                sink_hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Offer one request. Call right after a falling edge; returns right after
    // the falling edge that follows acceptance, so valid may stay high into
    // the next request without being lowered in between.
    task automatic send_request(input logic [1:0] cmd, input int left, input int top,
                                input int right, input int bottom, input int row);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_left_px    <= left[PX_W-1:0];
        s_top_px     <= top[PX_W-1:0];
        s_right_px   <= right[PX_W-1:0];
        s_bottom_px  <= bottom[PX_W-1:0];
        s_row_select <= row[SEL_W-1:0];
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic int any_px();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // Mostly rectangles near the map so marks land, clamp and overlap, plus
    // reads of live rows; the rest is clears, the unused code and full-range noise.
    task automatic send_random_request();
        int pick;
        int x;
        int y;
        pick = $urandom_range(99);
        if (pick < 58) begin
            x = int'($urandom_range(MAP_COLUMNS * TILE_PX + 60)) - 40;
            y = int'($urandom_range(MAP_ROWS * TILE_PX + 70)) - 40;
            send_request(CMD_MARK, x, y, x + int'($urandom_range(120)) - 8,
                         y + int'($urandom_range(100)) - 8, $urandom_range(63));
        end else if (pick < 78) begin
            send_request(CMD_READ, any_px(), any_px(), any_px(), any_px(),
                         ($urandom_range(99) < 85) ? $urandom_range(MAP_ROWS - 1)
                                                   : $urandom_range(63));
        end else if (pick < 82) begin
            send_request(CMD_CLEAR, any_px(), any_px(), any_px(), any_px(),
                         $urandom_range(63));
        end else if (pick < 84) begin
            send_request(CMD_UNUSED, any_px(), any_px(), any_px(), any_px(),
                         $urandom_range(63));
        end else begin
            send_request(CMD_MARK, any_px(), any_px(), any_px(), any_px(),
                         $urandom_range(63));
        end
    endtask

    // Hold until the checker owes no more responses.
    task automatic wait_until_drained();
        while (responses_owed != 0) @(negedge aclk);
    endtask

    initial begin
        src_idle_pct  = 25;
        sink_idle_pct = 58;

        // Hold reset, then release at a falling edge.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed requests: empty map, full-range clamp, each rejection,
        // the top-at-height quirk, an empty range and the odd commands.
        send_request(CMD_READ, 0, 0, 0, 0, 0);
        send_request(CMD_MARK, -32768, -32768, 32767, 32767, 63);
        send_request(CMD_READ, 0, 0, 0, 0, 0);
        send_request(CMD_READ, 0, 0, 0, 0, MAP_ROWS - 1);
        send_request(CMD_READ, 0, 0, 0, 0, MAP_ROWS);
        send_request(CMD_READ, 0, 0, 0, 0, 63);
        send_request(CMD_CLEAR, 0, 0, 0, 0, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 5);
        // Left tile on the last column is rejected; one column in still marks.
        send_request(CMD_MARK, (MAP_COLUMNS - 1) * TILE_PX, 0, 32767, 40, 0);
        send_request(CMD_MARK, (MAP_COLUMNS - 2) * TILE_PX, 0,
                     (MAP_COLUMNS - 1) * TILE_PX - 1, 20, 0);
        send_request(CMD_MARK, 32767, 0, 32767, 0, 0);
        // Top tile past the height is rejected; equal to it is accepted, marks nothing.
        send_request(CMD_MARK, 0, (MAP_ROWS + 1) * TILE_PX, 100, 32767, 0);
        send_request(CMD_MARK, 0, MAP_ROWS * TILE_PX, 100, 32767, 0);
        // Right or bottom tile negative is rejected.
        send_request(CMD_MARK, -100, 0, -1, 50, 0);
        send_request(CMD_MARK, 0, -100, 50, -TILE_PX, 0);
        // Left past right: accepted, nothing set.
        send_request(CMD_MARK, 100, 30, 50, 60, 0);
        // Negative corners round down and clamp to tile zero.
        send_request(CMD_MARK, -1, -1, 0, 0, 0);
        send_request(CMD_UNUSED, 32767, 32767, -32768, -32768, 63);
        send_request(CMD_READ, -32768, 32767, -32768, 32767, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 1);
        send_request(CMD_READ, 0, 0, 0, 0, MAP_ROWS - 1);

        // Phase 1: sender idles a quarter of the time, receiver more than half.
        repeat (RANDOM_PER_PHASE) send_random_request();

        // Pause the sender until every owed response is out.
        s_valid <= 1'b0;
        wait_until_drained();

        // Phase 2: swap the idle rates.
        src_idle_pct  = 58;
        sink_idle_pct = 25;
        repeat (RANDOM_PER_PHASE) send_random_request();

        // Phase 3: no idling, opened by a long receiver hold so the pipeline
        // fills and s_ready drops while requests keep coming.
        src_idle_pct     = 0;
        sink_idle_pct    = 0;
        sink_hold_cycles = LONG_HOLD_CYCLES;
        repeat (RANDOM_PER_PHASE) send_random_request();

        s_valid <= 1'b0;
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("dirty_tile_rect_marker_tb: done, clean");
        end else begin
            $display("dirty_tile_rect_marker_tb: done, errors");
        end
        $finish;
    end

endmodule
